// ----- hw/rtl/spf_pkg.sv -----
// Shared constants for the sieve-based prime factor counter.
// No dependencies.
package spf_pkg;
  localparam int unsigned TableLimit = 1048576;
  localparam int unsigned PrimeDepth = 131072;
  localparam int unsigned VW = 20;
  localparam int unsigned AW = $clog2(TableLimit);
  localparam int unsigned PW = $clog2(PrimeDepth);
  localparam int unsigned LW = PW + 1;
endpackage

// ----- hw/rtl/spf_divider.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on spf_pkg.
module spf_divider import spf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [VW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [VW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);
  logic [VW-1:0] q_q, q_d, r_q, r_d, dv_q;
  logic [VW-1:0] q_step, r_step;
  logic [4:0]    cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [VW:0]   sh;

  // One restoring step on the current partial remainder
  always_comb begin
    sh = {r_q, q_q[VW-1]};
    q_step = {q_q[VW-2:0], 1'b0};
    if (sh >= {1'b0, dv_q}) begin
      r_step = VW'(sh - {1'b0, dv_q});
      q_step[0] = 1'b1;
    end else begin
      r_step = sh[VW-1:0];
    end
  end

  // Next state: step while busy, a start reloads
  always_comb begin
    q_d = q_q; r_d = r_q; cnt_d = cnt_q; busy_d = busy_q;
    if (busy_q) begin
      q_d = q_step; r_d = r_step;
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
    if (start_i) begin
      q_d = dividend_i; r_d = '0; cnt_d = 5'(VW); busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; q_q <= '0; r_q <= '0; dv_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; q_q <= q_d; r_q <= r_d;
      if (start_i) dv_q <= divisor_i;
    end
  end

  // Final quotient and remainder are valid in the done cycle
  assign done_o = busy_q && (cnt_q == 5'd1);
  assign quot_o = q_step;
  assign rem_o  = r_step;
endmodule

// ----- hw/rtl/spf_sieve_factor_counter_top.sv -----
// Top level: sieve sequencer, factor table and prime list memories, query engine.
// Depends on spf_pkg and spf_divider.
//
// Usage: after reset the block first clears the factor table, one entry per
// cycle, then runs a linear sieve, writing the smallest prime factor of
// every value below the table limit and collecting primes in a list. Each
// value passes S_X and S_XCHK, then S_INNER, S_PRD and S_PCHK for each
// inner step; in_ready_o stays low until the sieve is done.
// Each accepted query_value_i item is factorised by table lookup and
// repeated division with a bit-serial divider; each prime costs one
// division more than its exponent. One item is handled at a time; the
// next is accepted the cycle after the previous result is registered.
// The result sits in an output register until taken. While it waits the
// engine still accepts and processes the next item, which holds until the
// register is free. Values 0 and 1 give zero counts; values at or above
// the limit set out_of_range_o with zero counts.
module spf_sieve_factor_counter_top import spf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [19:0]   query_value_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [4:0]    total_factor_count_o,
  output logic [2:0]    distinct_prime_count_o,
  output logic          out_of_range_o
);
  typedef enum logic [3:0] {
    S_CLR, S_X, S_XCHK, S_INNER, S_PRD, S_PCHK,
    S_IDLE, S_QRD, S_QCHK, S_QDIV, S_DONE
  } state_e;

  state_e st_q;
  logic [VW-1:0] spf_mem [TableLimit];
  logic [VW-1:0] pl_mem  [PrimeDepth];
  logic [VW-1:0] spf_rd_q, pl_rd_q;
  logic          spf_we, pl_we;
  logic [AW-1:0] spf_wa, spf_ra;
  logic [VW-1:0] spf_wd;
  logic [PW-1:0] pl_ra;

  logic [AW:0]   x_q;
  logic [LW-1:0] plen_q, i_q;
  logic [VW-1:0] p_q, fx_q, t_q, cur_q;
  logic [4:0]    tot_q;
  logic [2:0]    dis_q;
  logic          oor_q;
  logic          out_valid_q;
  logic [4:0]    out_tot_q;
  logic [2:0]    out_dis_q;
  logic          out_oor_q;
  logic [2*VW:0] m;
  logic          mark_ok, q_oor;
  logic [VW-1:0] spf_fac;
  logic          dstart, ddone;
  logic [VW-1:0] da, db, dq, dr;

  // Table memories
  always_ff @(posedge clk_i) begin
    if (spf_we) spf_mem[spf_wa] <= spf_wd;
    spf_rd_q <= spf_mem[spf_ra];
    if (pl_we) pl_mem[plen_q[PW-1:0]] <= x_q[VW-1:0];
    pl_rd_q <= pl_mem[pl_ra];
  end

  assign m = {1'b0, p_q} * {1'b0, x_q[VW-1:0]};
  assign mark_ok = m < (2*VW+1)'(TableLimit);
  assign spf_ra = (st_q == S_QRD) ? t_q[AW-1:0] : x_q[AW-1:0];
  assign pl_ra  = i_q[PW-1:0];
  assign q_oor  = {1'b0, query_value_i} >= 21'(TableLimit);
  // Unmarked entry: value treated as its own factor
  assign spf_fac = (spf_rd_q < VW'(2)) ? t_q : spf_rd_q;

  // Memory write control: clearing pass, new primes and sieve marks
  always_comb begin
    spf_we = 1'b0; spf_wa = x_q[AW-1:0]; spf_wd = x_q[VW-1:0]; pl_we = 1'b0;
    if (st_q == S_CLR) begin
      spf_we = 1'b1; spf_wd = '0;
    end else if (st_q == S_XCHK && spf_rd_q == '0) begin
      spf_we = 1'b1;
      pl_we  = plen_q < LW'(PrimeDepth);
    end else if (st_q == S_PCHK && mark_ok) begin
      spf_we = 1'b1; spf_wa = m[AW-1:0]; spf_wd = p_q;
    end
  end

  // Divider feed: first division of a prime, then chained on the quotient
  assign da = (st_q == S_QDIV) ? dq : t_q;
  assign db = (st_q == S_QDIV) ? cur_q : spf_fac;
  assign dstart = (st_q == S_QCHK && t_q > VW'(1))
               || (st_q == S_QDIV && ddone && dr == '0);

  spf_divider u_div (
    .clk_i, .rst_ni, .start_i(dstart), .dividend_i(da), .divisor_i(db),
    .done_o(ddone), .quot_o(dq), .rem_o(dr)
  );

  // Sieve sequencer, query engine and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; x_q <= '0; plen_q <= '0; i_q <= '0; p_q <= '0; fx_q <= '0;
      t_q <= '0; cur_q <= '0; tot_q <= '0; dis_q <= '0; oor_q <= 1'b0;
      out_valid_q <= 1'b0; out_tot_q <= '0; out_dis_q <= '0; out_oor_q <= 1'b0;
    end else begin
      unique case (st_q)
        S_CLR: begin
          if (x_q == (AW+1)'(TableLimit - 1)) begin
            x_q <= (AW+1)'(2); st_q <= S_X;
          end else begin
            x_q <= x_q + (AW+1)'(1);
          end
        end
        S_X: st_q <= (x_q >= (AW+1)'(TableLimit)) ? S_IDLE : S_XCHK;
        S_XCHK: begin
          if (spf_rd_q == '0) begin
            fx_q <= x_q[VW-1:0];
            if (plen_q < LW'(PrimeDepth)) plen_q <= plen_q + LW'(1);
          end else begin
            fx_q <= spf_rd_q;
          end
          i_q <= '0; st_q <= S_INNER;
        end
        S_INNER: begin
          if (i_q < plen_q) st_q <= S_PRD;
          else begin x_q <= x_q + (AW+1)'(1); st_q <= S_X; end
        end
        S_PRD: begin
          p_q <= pl_rd_q; st_q <= S_PCHK;
        end
        // Stop at the smallest factor of x (that prime divides x) or once p * x is past the table
        S_PCHK: begin
          if (mark_ok && p_q != fx_q) begin
            i_q <= i_q + LW'(1); st_q <= S_INNER;
          end else begin
            x_q <= x_q + (AW+1)'(1); st_q <= S_X;
          end
        end
        S_IDLE: if (in_valid_i) begin
          t_q <= query_value_i; tot_q <= '0; dis_q <= '0;
          oor_q <= q_oor;
          st_q <= q_oor ? S_DONE : S_QRD;
        end
        S_QRD: st_q <= S_QCHK;
        S_QCHK: begin
          if (t_q > VW'(1)) begin
            cur_q <= spf_fac;
            dis_q <= dis_q + 3'd1; st_q <= S_QDIV;
          end else st_q <= S_DONE;
        end
        S_QDIV: if (ddone) begin
          if (dr == '0) begin t_q <= dq; tot_q <= tot_q + 5'd1; end
          else st_q <= S_QRD;
        end
        S_DONE: if (!out_valid_q || out_ready_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
      // Load a finished item, drop a taken one
      if (st_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
        out_tot_q <= tot_q; out_dis_q <= dis_q; out_oor_q <= oor_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o = (st_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign total_factor_count_o = out_tot_q;
  assign distinct_prime_count_o = out_dis_q;
  assign out_of_range_o = out_oor_q;

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |->
      total_factor_count_o == '0 && distinct_prime_count_o == '0)
    else $error("out of range item with nonzero counts");
  a_dis_le_tot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 5'(distinct_prime_count_o) <= total_factor_count_o)
    else $error("distinct count exceeds total");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(total_factor_count_o)
      && $stable(distinct_prime_count_o) && $stable(out_of_range_o))
    else $error("result dropped while stalled");
endmodule
